>>> hdl/csag_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the capture surface address generator.
// Used by every module of the block. Depends on nothing.

package csag_pkg;

    localparam int ADDR_W    = 32;
    localparam int DIM_W     = 14;
    localparam int STRIDE_W  = 17;
    localparam int LSTRIDE_W = 18;
    localparam int PROD_W    = 31;
    localparam int ISIZE_W   = 30;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 136;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARSER_COUNT = 3'd4;

    // field modes
    localparam logic [2:0] FM_ANY           = 3'd0;
    localparam logic [2:0] FM_NONE          = 3'd1;
    localparam logic [2:0] FM_INTERLACED    = 3'd2;
    localparam logic [2:0] FM_INTERLACED_TB = 3'd3;
    localparam logic [2:0] FM_INTERLACED_BT = 3'd4;
    localparam logic [2:0] FM_SEQ_TB        = 3'd5;
    localparam logic [2:0] FM_SEQ_BT        = 3'd6;

    // fourcc codes, first character in the low byte
    localparam logic [31:0] FMT_GREY = 32'h59455247;
    localparam logic [31:0] FMT_BA81 = 32'h31384142;
    localparam logic [31:0] FMT_GBRG = 32'h47524247;
    localparam logic [31:0] FMT_GRBG = 32'h47425247;
    localparam logic [31:0] FMT_RGGB = 32'h42474752;
    localparam logic [31:0] FMT_RGBO = 32'h4F424752;
    localparam logic [31:0] FMT_RGBP = 32'h50424752;
    localparam logic [31:0] FMT_BG10 = 32'h30314742;
    localparam logic [31:0] FMT_GB10 = 32'h30314247;
    localparam logic [31:0] FMT_BA10 = 32'h30314142;
    localparam logic [31:0] FMT_RG10 = 32'h30314752;
    localparam logic [31:0] FMT_BG12 = 32'h32314742;
    localparam logic [31:0] FMT_GB12 = 32'h32314247;
    localparam logic [31:0] FMT_BA12 = 32'h32314142;
    localparam logic [31:0] FMT_RG12 = 32'h32314752;
    localparam logic [31:0] FMT_YUYV = 32'h56595559;
    localparam logic [31:0] FMT_YVYU = 32'h55595659;
    localparam logic [31:0] FMT_UYVY = 32'h59565955;
    localparam logic [31:0] FMT_VYUY = 32'h59555956;
    localparam logic [31:0] FMT_RGB4 = 32'h34424752;
    localparam logic [31:0] FMT_422P = 32'h50323234;
    localparam logic [31:0] FMT_NV16 = 32'h3631564E;
    localparam logic [31:0] FMT_NV61 = 32'h3136564E;

    typedef enum logic [2:0] {
        FMT_CLASS_NONE,
        FMT_CLASS_BPP1,
        FMT_CLASS_BPP2,
        FMT_CLASS_BPP4,
        FMT_CLASS_YUV422P,
        FMT_CLASS_NV16
    } fmt_class_t;

    typedef struct packed {
        logic [31:0]      pixel_format;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [2:0]       field_mode;
        logic [1:0]       parser_count;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        base;
        logic [2:0][STRIDE_W-1:0] s;
        logic [1:0]               planes;
        logic                     err;
        logic                     two_parsers;
    } stride_t;

    typedef struct packed {
        logic [2:0][ADDR_W-1:0]    top;
        logic [2:0][ADDR_W-1:0]    bot;
        logic [2:0][LSTRIDE_W-1:0] stride;
        logic [2:0][STRIDE_W-1:0]  half;
        logic [STRIDE_W-1:0]       bpl;
        logic [ISIZE_W-1:0]        isize;
        logic [1:0]                planes;
        logic                      err;
        logic                      two_parsers;
    } job_t;

    function automatic logic [STRIDE_W-1:0] round64(input logic [STRIDE_W-1:0] v);
        logic [10:0] q;
        q = v[16:6] + 11'(|v[5:0]);
        return {q, 6'b0};
    endfunction

    function automatic fmt_class_t fmt_class(input logic [31:0] code);
        fmt_class_t c;
        unique case (code)
            FMT_GREY, FMT_BA81, FMT_GBRG, FMT_GRBG, FMT_RGGB: c = FMT_CLASS_BPP1;
            FMT_RGBO, FMT_RGBP, FMT_BG10, FMT_GB10, FMT_BA10, FMT_RG10,
            FMT_BG12, FMT_GB12, FMT_BA12, FMT_RG12,
            FMT_YUYV, FMT_YVYU, FMT_UYVY, FMT_VYUY:           c = FMT_CLASS_BPP2;
            FMT_RGB4:                                         c = FMT_CLASS_BPP4;
            FMT_422P:                                         c = FMT_CLASS_YUV422P;
            FMT_NV16, FMT_NV61:                               c = FMT_CLASS_NV16;
            default:                                          c = FMT_CLASS_NONE;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/capture_surface_address_gen.sv
`timescale 1ns / 1ps
// Top level of the capture surface address generator.
// Depends on csag_pkg, csag_stride, csag_layout and csag_emit.
//
// Usage: write the format, size, field mode and parser count registers through the
// cfg_wr_* port while no buffer is in flight. Each transaction on the s_axis channel
// carries one buffer base address. For it the m_axis channel gives one transaction per
// plane and parser (plane outer, parser inner), tlast on the final one; an unsupported
// format gives a single transaction with tuser set and zero tdata.
// The first result of a buffer passes the input register, layout stages B, C and D and
// the output register. A buffer gives planes * parsers results (1 to 6); the single
// result sequencer feeding it gives one result per cycle while m_axis_tready is high.
// A four-deep register pipeline sits in front of the output register, so up to four
// buffers are accepted while results are still waiting.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
// When m_axis_tready is low the output holds and the pipeline fills, then s_axis_tready
// drops until results are taken again.

module capture_surface_address_gen (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [csag_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [csag_pkg::CFG_DAT_W-1:0]       cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // buffer_base_address[31:0]
    input  logic [csag_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // plane_index[1:0], parser_index[2], top_field_address[34:3],
    // bottom_field_address[66:35], line_stride[84:67], bytes_per_line[101:85],
    // image_size[131:102], plane_count[133:132], zero pad[135:134]
    output logic [csag_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // format_error[0]
    output logic                                 m_axis_tuser,
    // last_result
    output logic                                 m_axis_tlast
);

    csag_pkg::cfg_t    cfg_reg, cfg_next;
    logic              st_valid, st_ready;
    csag_pkg::stride_t st;
    logic              job_valid, job_pop;
    csag_pkg::job_t    job;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                csag_pkg::CFG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_wr_data;
                csag_pkg::CFG_FRAME_WIDTH:
                    cfg_next.frame_width = cfg_wr_data[csag_pkg::DIM_W-1:0];
                csag_pkg::CFG_FRAME_HEIGHT:
                    cfg_next.frame_height = cfg_wr_data[csag_pkg::DIM_W-1:0];
                csag_pkg::CFG_FIELD_MODE:   cfg_next.field_mode = cfg_wr_data[2:0];
                csag_pkg::CFG_PARSER_COUNT: cfg_next.parser_count = cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format <= '0;
            cfg_reg.frame_width  <= '0;
            cfg_reg.frame_height <= '0;
            cfg_reg.field_mode   <= csag_pkg::FM_ANY;
            cfg_reg.parser_count <= 2'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    csag_stride u_stride (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_base  (s_axis_tdata[csag_pkg::ADDR_W-1:0]),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st       (st)
    );

    csag_layout u_layout (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .st_valid  (st_valid),
        .st_ready  (st_ready),
        .st        (st),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    csag_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .job           (job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/csag_stride.sv
`timescale 1ns / 1ps
// Input register stage: captures the buffer base and the per-plane strides of the format.
// Depends on csag_pkg.

module csag_stride (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csag_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [csag_pkg::ADDR_W-1:0]       in_base,
    output logic                              st_valid,
    input  logic                              st_ready,
    output csag_pkg::stride_t                 st
);

    logic                 valid_reg;
    logic                 valid_next;
    csag_pkg::stride_t    st_reg;
    csag_pkg::stride_t    st_next;
    csag_pkg::fmt_class_t cls;
    logic [csag_pkg::STRIDE_W-1:0] w17;
    logic [csag_pkg::STRIDE_W-1:0] r1;
    logic [csag_pkg::STRIDE_W-1:0] r2;
    logic [csag_pkg::STRIDE_W-1:0] r4;
    logic [csag_pkg::STRIDE_W-1:0] rh;
    logic                 load;

    assign in_ready = !valid_reg || st_ready;
    assign load     = in_valid && in_ready;
    assign st_valid = valid_reg;
    assign st       = st_reg;

    always_comb begin
        cls = csag_pkg::fmt_class(cfg.pixel_format);
        w17 = csag_pkg::STRIDE_W'(cfg.frame_width);
        r1  = csag_pkg::round64(w17);
        r2  = csag_pkg::round64(w17 << 1);
        r4  = csag_pkg::round64(w17 << 2);
        rh  = csag_pkg::round64(w17 >> 1);

        st_next             = '0;
        st_next.base        = in_base;
        st_next.two_parsers = cfg.parser_count[1];
        unique case (cls)
            csag_pkg::FMT_CLASS_BPP1: begin
                st_next.s[0]   = r1;
                st_next.planes = 2'd1;
            end
            csag_pkg::FMT_CLASS_BPP2: begin
                st_next.s[0]   = r2;
                st_next.planes = 2'd1;
            end
            csag_pkg::FMT_CLASS_BPP4: begin
                st_next.s[0]   = r4;
                st_next.planes = 2'd1;
            end
            csag_pkg::FMT_CLASS_YUV422P: begin
                st_next.s[0]   = rh << 1;
                st_next.s[1]   = rh;
                st_next.s[2]   = rh;
                st_next.planes = 2'd3;
            end
            csag_pkg::FMT_CLASS_NV16: begin
                st_next.s[0]   = r1;
                st_next.s[1]   = r1;
                st_next.planes = 2'd2;
            end
            default: begin
                st_next.err = 1'b1;
            end
        endcase

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            st_reg <= st_next;
        end
    end

endmodule

>>> hdl/csag_layout.sv
`timescale 1ns / 1ps
// Plane layout pipeline: plane sizes, field offsets, then top/bottom addresses per plane.
// Three register stages. Depends on csag_pkg.

module csag_layout (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csag_pkg::cfg_t       cfg,
    input  logic                 st_valid,
    output logic                 st_ready,
    input  csag_pkg::stride_t    st,
    output logic                 job_valid,
    input  logic                 job_pop,
    output csag_pkg::job_t       job
);

    typedef struct packed {
        logic [csag_pkg::ADDR_W-1:0]        base;
        logic [2:0][csag_pkg::STRIDE_W-1:0] s;
        logic [2:0][csag_pkg::PROD_W-1:0]   p;
        logic [1:0]                         planes;
        logic                               err;
        logic                               two_parsers;
    } prod_t;

    typedef struct packed {
        logic [csag_pkg::ADDR_W-1:0]        base;
        logic [2:0][csag_pkg::STRIDE_W-1:0] s;
        logic [2:0][csag_pkg::ADDR_W-1:0]   fa;
        logic [csag_pkg::ADDR_W-1:0]        span;
        logic [csag_pkg::ISIZE_W-1:0]       isize;
        logic [1:0]                         planes;
        logic                               err;
        logic                               two_parsers;
    } offs_t;

    logic            vb_reg, vc_reg, vd_reg;
    logic            vb_next, vc_next, vd_next;
    logic            rdy_b, rdy_c, rdy_d;
    prod_t           b_reg, b_next;
    offs_t           c_reg, c_next;
    csag_pkg::job_t  d_reg, d_next;
    logic            interlaced, sequential, bottom_first;
    logic [2:0][csag_pkg::PROD_W-1:0] q;
    logic [csag_pkg::ADDR_W-1:0]      isum;
    logic [csag_pkg::ADDR_W-1:0]      first_a, second_a, ext;

    always_comb begin
        interlaced   = (cfg.field_mode == csag_pkg::FM_INTERLACED) ||
                       (cfg.field_mode == csag_pkg::FM_INTERLACED_TB) ||
                       (cfg.field_mode == csag_pkg::FM_INTERLACED_BT);
        sequential   = (cfg.field_mode == csag_pkg::FM_SEQ_TB) ||
                       (cfg.field_mode == csag_pkg::FM_SEQ_BT);
        bottom_first = (cfg.field_mode == csag_pkg::FM_INTERLACED_BT) ||
                       (cfg.field_mode == csag_pkg::FM_SEQ_BT);
    end

    assign rdy_d     = !vd_reg || job_pop;
    assign rdy_c     = !vc_reg || rdy_d;
    assign rdy_b     = !vb_reg || rdy_c;
    assign st_ready  = rdy_b;
    assign job_valid = vd_reg;
    assign job       = d_reg;

    // stage B: plane sizes
    always_comb begin
        b_next.base        = st.base;
        b_next.s           = st.s;
        b_next.planes      = st.planes;
        b_next.err         = st.err;
        b_next.two_parsers = st.two_parsers;
        for (int i = 0; i < 3; i++) begin
            b_next.p[i] = csag_pkg::PROD_W'(st.s[i]) * csag_pkg::PROD_W'(cfg.frame_height);
        end
    end

    // stage C: first-field offsets, half-frame span, image size
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q[i] = sequential ? (b_reg.p[i] >> 1) : b_reg.p[i];
        end
        isum = csag_pkg::ADDR_W'(b_reg.p[0]) + csag_pkg::ADDR_W'(b_reg.p[1]) +
               csag_pkg::ADDR_W'(b_reg.p[2]);
        c_next.base        = b_reg.base;
        c_next.s           = b_reg.s;
        c_next.planes      = b_reg.planes;
        c_next.err         = b_reg.err;
        c_next.two_parsers = b_reg.two_parsers;
        c_next.fa[0]       = '0;
        c_next.fa[1]       = csag_pkg::ADDR_W'(q[0]);
        c_next.fa[2]       = csag_pkg::ADDR_W'(q[0]) + csag_pkg::ADDR_W'(q[1]);
        c_next.span        = csag_pkg::ADDR_W'(b_reg.p[0] >> 1) +
                             csag_pkg::ADDR_W'(b_reg.p[1] >> 1) +
                             csag_pkg::ADDR_W'(b_reg.p[2] >> 1);
        c_next.isize       = isum[csag_pkg::ISIZE_W-1:0];
    end

    // stage D: absolute addresses, line strides and parser offsets
    always_comb begin
        d_next.planes      = c_reg.planes;
        d_next.err         = c_reg.err;
        d_next.two_parsers = c_reg.two_parsers;
        d_next.isize       = c_reg.isize;
        d_next.bpl         = c_reg.s[0];
        first_a  = '0;
        second_a = '0;
        ext      = '0;
        for (int i = 0; i < 3; i++) begin
            ext      = interlaced ? csag_pkg::ADDR_W'(c_reg.s[i]) : c_reg.span;
            first_a  = c_reg.base + c_reg.fa[i];
            second_a = c_reg.base + c_reg.fa[i] + ext;
            d_next.top[i] = bottom_first ? second_a : first_a;
            if (interlaced || sequential) begin
                d_next.bot[i] = bottom_first ? first_a : second_a;
            end else begin
                d_next.bot[i] = '0;
            end
            d_next.stride[i] = interlaced ? {c_reg.s[i], 1'b0} : {1'b0, c_reg.s[i]};
            d_next.half[i]   = interlaced ? c_reg.s[i] : (c_reg.s[i] >> 1);
        end
    end

    always_comb begin
        vb_next = rdy_b ? st_valid : vb_reg;
        vc_next = rdy_c ? vb_reg : vc_reg;
        vd_next = rdy_d ? vc_reg : vd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vd_reg <= vd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_b) begin
            b_reg <= b_next;
        end
        if (rdy_c) begin
            c_reg <= c_next;
        end
        if (rdy_d) begin
            d_reg <= d_next;
        end
    end

endmodule

>>> hdl/csag_emit.sv
`timescale 1ns / 1ps
// Result sequencer: walks planes and parsers of one job and drives the output register.
// Depends on csag_pkg.

module csag_emit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 job_valid,
    output logic                                 job_pop,
    input  csag_pkg::job_t                       job,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [csag_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic [1:0]  plane_reg, plane_next;
    logic        parser_reg, parser_next;
    logic        m_valid_reg, m_valid_next;
    logic [csag_pkg::OUT_DATA_W-1:0] data_reg, data_next;
    logic        err_reg, err_next;
    logic        last_reg, last_next;
    logic        load;
    logic        last_sel;
    logic [csag_pkg::ADDR_W-1:0]    sel_top, sel_bot, top_addr;
    logic [csag_pkg::LSTRIDE_W-1:0] sel_stride;
    logic [csag_pkg::STRIDE_W-1:0]  sel_half;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = err_reg;
    assign m_axis_tlast  = last_reg;

    always_comb begin
        unique case (plane_reg)
            2'd0: begin
                sel_top    = job.top[0];
                sel_bot    = job.bot[0];
                sel_stride = job.stride[0];
                sel_half   = job.half[0];
            end
            2'd1: begin
                sel_top    = job.top[1];
                sel_bot    = job.bot[1];
                sel_stride = job.stride[1];
                sel_half   = job.half[1];
            end
            default: begin
                sel_top    = job.top[2];
                sel_bot    = job.bot[2];
                sel_stride = job.stride[2];
                sel_half   = job.half[2];
            end
        endcase

        top_addr = sel_top + (parser_reg ? csag_pkg::ADDR_W'(sel_half) : '0);
        last_sel = job.err ||
                   ((plane_reg == job.planes - 2'd1) && (parser_reg || !job.two_parsers));
        load     = job_valid && (!m_valid_reg || m_axis_tready);
        job_pop  = load && last_sel;

        plane_next  = plane_reg;
        parser_next = parser_reg;
        if (load) begin
            if (last_sel) begin
                plane_next  = '0;
                parser_next = 1'b0;
            end else if (job.two_parsers && !parser_reg) begin
                parser_next = 1'b1;
            end else begin
                parser_next = 1'b0;
                plane_next  = plane_reg + 2'd1;
            end
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        // tdata: plane, parser, top, bottom, line stride, bytes per line, size, planes
        if (job.err) begin
            data_next = '0;
        end else begin
            data_next = {2'b00, job.planes, job.isize, job.bpl, sel_stride,
                         sel_bot, top_addr, parser_reg, plane_reg};
        end
        err_next  = job.err;
        last_next = last_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg   <= '0;
            parser_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            plane_reg   <= plane_next;
            parser_reg  <= parser_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            err_reg  <= err_next;
            last_reg <= last_next;
        end
    end

endmodule

>>> hdl/csag_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the capture surface address generator, bound to the top level.
// Depends on csag_pkg.

module csag_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [csag_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // error transaction is alone and empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("error result not a lone zero transaction");

    // plane index below plane count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            (m_axis_tdata[1:0] < m_axis_tdata[133:132]))
        else $error("plane index out of range");

    // final transaction belongs to the last plane
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser && m_axis_tlast |->
            (m_axis_tdata[1:0] + 2'd1 == m_axis_tdata[133:132]))
        else $error("tlast before last plane");

endmodule

bind capture_surface_address_gen csag_checker u_csag_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for capture_surface_address_gen: a directed table, then random
// configurations and buffers, each result checked against a typed-in value or an in-bench surface predictor.
// Depends on csag_pkg and the capture_surface_address_gen RTL only.

module testbench;

    localparam int PIPE_LATENCY = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 40;
    localparam int ALIGN        = 64;
    localparam int NUM_KNOWN    = 23;
    localparam logic [31:0] KNOWN_FMTS [0:NUM_KNOWN-1] = '{
        csag_pkg::FMT_GREY, csag_pkg::FMT_BA81, csag_pkg::FMT_GBRG, csag_pkg::FMT_GRBG,
        csag_pkg::FMT_RGGB,
        csag_pkg::FMT_RGBO, csag_pkg::FMT_RGBP, csag_pkg::FMT_BG10, csag_pkg::FMT_GB10,
        csag_pkg::FMT_BA10, csag_pkg::FMT_RG10,
        csag_pkg::FMT_BG12, csag_pkg::FMT_GB12, csag_pkg::FMT_BA12, csag_pkg::FMT_RG12,
        csag_pkg::FMT_YUYV, csag_pkg::FMT_YVYU, csag_pkg::FMT_UYVY, csag_pkg::FMT_VYUY,
        csag_pkg::FMT_RGB4, csag_pkg::FMT_422P, csag_pkg::FMT_NV16, csag_pkg::FMT_NV61
    };
    localparam logic [2:0] FM_SEVEN = 3'(csag_pkg::FM_SEQ_BT + 1);

    typedef struct packed {
        logic [1:0]  plane;
        logic        parser;
        logic [31:0] top;
        logic [31:0] bot;
        logic [17:0] stride;
        logic [16:0] bpl;
        logic [29:0] isize;
        logic [1:0]  planes;
        logic        err;
        logic        is_last;
    } surface_result_t;

    typedef struct {
        bit              set_cfg;
        csag_pkg::cfg_t  cfg;
        logic [31:0]     base;
        bit              typed;
        surface_result_t want;
    } stim_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_wr_en;
    logic [csag_pkg::CFG_IDX_W-1:0]      cfg_addr;
    logic [csag_pkg::CFG_DAT_W-1:0]      cfg_wr_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [csag_pkg::IN_DATA_W-1:0]      s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [csag_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tuser;
    logic                                m_axis_tlast;

    csag_pkg::cfg_t    csr;
    surface_result_t   surf_expected [$];
    stim_row_t         stim_rows [$];
    int                error_count;
    int                send_idle_pct;
    int                recv_stall_pct;

    capture_surface_address_gen i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("** capture_surface_address_gen: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] align64(input logic [31:0] v);
        return ((v + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    function automatic surface_result_t format_error_result();
        surface_result_t r;
        r = '0;
        r.err = 1'b1;
        r.is_last = 1'b1;
        return r;
    endfunction

    function automatic surface_result_t single_plane(input logic [31:0] base,
                                                     input logic [17:0] stride,
                                                     input logic [29:0] isize);
        surface_result_t r;
        r = '0;
        r.top = base;
        r.stride = stride;
        r.bpl = stride[16:0];
        r.isize = isize;
        r.planes = 2'd1;
        r.is_last = 1'b1;
        return r;
    endfunction

    // expected surface programming for one buffer under the current registers
    function automatic void compute_surfaces(input logic [31:0] base);
        logic [31:0] s [3];
        logic [31:0] top [3];
        logic [31:0] bot [3];
        logic [31:0] half [3];
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] bpl;
        logic [31:0] isize;
        int planes;
        int parsers;
        surface_result_t r;
        w = 32'(csr.frame_width);
        h = 32'(csr.frame_height);
        for (int i = 0; i < 3; i++) begin
            s[i] = '0;
            top[i] = '0;
            bot[i] = '0;
        end
        planes = 0;
        case (csr.pixel_format)
            csag_pkg::FMT_GREY, csag_pkg::FMT_BA81, csag_pkg::FMT_GBRG,
            csag_pkg::FMT_GRBG, csag_pkg::FMT_RGGB: begin
                s[0] = align64(w);
                planes = 1;
            end
            csag_pkg::FMT_RGBO, csag_pkg::FMT_RGBP, csag_pkg::FMT_BG10,
            csag_pkg::FMT_GB10, csag_pkg::FMT_BA10, csag_pkg::FMT_RG10,
            csag_pkg::FMT_BG12, csag_pkg::FMT_GB12, csag_pkg::FMT_BA12,
            csag_pkg::FMT_RG12, csag_pkg::FMT_YUYV, csag_pkg::FMT_YVYU,
            csag_pkg::FMT_UYVY, csag_pkg::FMT_VYUY: begin
                s[0] = align64(w * 2);
                planes = 1;
            end
            csag_pkg::FMT_RGB4: begin
                s[0] = align64(w * 4);
                planes = 1;
            end
            csag_pkg::FMT_422P: begin
                s[1] = align64(w / 2);
                s[2] = s[1];
                s[0] = s[1] * 2;
                planes = 3;
            end
            csag_pkg::FMT_NV16, csag_pkg::FMT_NV61: begin
                s[0] = align64(w);
                s[1] = s[0];
                planes = 2;
            end
            default: planes = 0;
        endcase
        if (planes == 0) begin
            surf_expected.push_back(format_error_result());
            return;
        end
        bpl = s[0];
        isize = (s[0] + s[1] + s[2]) * h;
        for (int i = 0; i < 3; i++)
            half[i] = (s[i] * h) >> 1;
        case (csr.field_mode)
            csag_pkg::FM_INTERLACED, csag_pkg::FM_INTERLACED_TB: begin
                top[0] = base;
                top[1] = top[0] + s[0] * h;
                top[2] = top[1] + s[1] * h;
                for (int i = 0; i < 3; i++) begin
                    bot[i] = top[i] + s[i];
                    s[i] = s[i] * 2;
                end
            end
            csag_pkg::FM_INTERLACED_BT: begin
                bot[0] = base;
                bot[1] = bot[0] + s[0] * h;
                bot[2] = bot[1] + s[1] * h;
                for (int i = 0; i < 3; i++) begin
                    top[i] = bot[i] + s[i];
                    s[i] = s[i] * 2;
                end
            end
            csag_pkg::FM_SEQ_TB: begin
                top[0] = base;
                top[1] = top[0] + half[0];
                top[2] = top[1] + half[1];
                bot[0] = top[2] + half[2];
                bot[1] = bot[0] + half[0];
                bot[2] = bot[1] + half[1];
            end
            csag_pkg::FM_SEQ_BT: begin
                bot[0] = base;
                bot[1] = bot[0] + half[0];
                bot[2] = bot[1] + half[1];
                top[0] = bot[2] + half[2];
                top[1] = top[0] + half[0];
                top[2] = top[1] + half[1];
            end
            default: begin
                top[0] = base;
                top[1] = top[0] + s[0] * h;
                top[2] = top[1] + s[1] * h;
            end
        endcase
        parsers = (csr.parser_count >= 2) ? 2 : 1;
        for (int i = 0; i < planes; i++) begin
            for (int p = 0; p < parsers; p++) begin
                r.plane = 2'(i);
                r.parser = 1'(p);
                r.top = top[i] + 32'(p) * (s[i] / 2);
                r.bot = bot[i];
                r.stride = s[i][17:0];
                r.bpl = bpl[16:0];
                r.isize = isize[29:0];
                r.planes = 2'(planes);
                r.err = 1'b0;
                r.is_last = (i == planes - 1) && (p == parsers - 1);
                surf_expected.push_back(r);
            end
        end
    endfunction

    function automatic void add_row(input bit set_cfg, input csag_pkg::cfg_t cfg,
                                    input logic [31:0] base, input bit typed,
                                    input surface_result_t want);
        stim_row_t row;
        row.set_cfg = set_cfg;
        row.cfg = cfg;
        row.base = base;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [csag_pkg::DIM_W-1:0] random_dimension();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return csag_pkg::DIM_W'($urandom_range(1, 96));
            default: return csag_pkg::DIM_W'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic logic [31:0] random_base();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            default: return $urandom();
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    task automatic write_reg(input logic [csag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = data;
        case (idx)
            csag_pkg::CFG_PIXEL_FORMAT: csr.pixel_format = data;
            csag_pkg::CFG_FRAME_WIDTH:  csr.frame_width = data[csag_pkg::DIM_W-1:0];
            csag_pkg::CFG_FRAME_HEIGHT: csr.frame_height = data[csag_pkg::DIM_W-1:0];
            csag_pkg::CFG_FIELD_MODE:   csr.field_mode = data[2:0];
            csag_pkg::CFG_PARSER_COUNT: csr.parser_count = data[1:0];
            default: ;
        endcase
    endtask

    // optional junk in the unused upper bits of the non-format registers, plus an unmapped-index write
    task automatic program_config(input csag_pkg::cfg_t c, input bit junk_bits);
        logic [31:0] junk;
        junk = junk_bits ? $urandom() : '0;
        write_reg(csag_pkg::CFG_PIXEL_FORMAT, c.pixel_format);
        write_reg(csag_pkg::CFG_FRAME_WIDTH, {junk[31:csag_pkg::DIM_W], c.frame_width});
        write_reg(csag_pkg::CFG_FRAME_HEIGHT, {junk[31:csag_pkg::DIM_W], c.frame_height});
        write_reg(csag_pkg::CFG_FIELD_MODE, {junk[31:3], c.field_mode});
        write_reg(csag_pkg::CFG_PARSER_COUNT, {junk[31:2], c.parser_count});
        if (junk_bits)
            write_reg(csag_pkg::CFG_IDX_W'($urandom_range(csag_pkg::CFG_PARSER_COUNT + 1,
                                                          (1 << csag_pkg::CFG_IDX_W) - 1)),
                      $urandom());
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (surf_expected.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic send_buffer(input logic [31:0] base, input bit typed,
                               input surface_result_t want);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = base;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (typed)
            surf_expected.push_back(want);
        else
            compute_surfaces(base);
    endtask

    task automatic check_surface(input surface_result_t got, input surface_result_t want);
        if (got.plane != want.plane)
            report_mismatch("plane_index", 64'(got.plane), 64'(want.plane));
        if (got.parser != want.parser)
            report_mismatch("parser_index", 64'(got.parser), 64'(want.parser));
        if (got.top != want.top)
            report_mismatch("top_field_address", 64'(got.top), 64'(want.top));
        if (got.bot != want.bot)
            report_mismatch("bottom_field_address", 64'(got.bot), 64'(want.bot));
        if (got.stride != want.stride)
            report_mismatch("line_stride", 64'(got.stride), 64'(want.stride));
        if (got.bpl != want.bpl)
            report_mismatch("bytes_per_line", 64'(got.bpl), 64'(want.bpl));
        if (got.isize != want.isize)
            report_mismatch("image_size", 64'(got.isize), 64'(want.isize));
        if (got.planes != want.planes)
            report_mismatch("plane_count", 64'(got.planes), 64'(want.planes));
        if (got.err != want.err)
            report_mismatch("format_error", 64'(got.err), 64'(want.err));
        if (got.is_last != want.is_last)
            report_mismatch("tlast", 64'(got.is_last), 64'(want.is_last));
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        surface_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.plane   = m_axis_tdata[1:0];
            got.parser  = m_axis_tdata[2];
            got.top     = m_axis_tdata[34:3];
            got.bot     = m_axis_tdata[66:35];
            got.stride  = m_axis_tdata[84:67];
            got.bpl     = m_axis_tdata[101:85];
            got.isize   = m_axis_tdata[131:102];
            got.planes  = m_axis_tdata[133:132];
            got.err     = m_axis_tuser;
            got.is_last = m_axis_tlast;
            if (m_axis_tdata[135:134] != '0)
                report_mismatch("tdata pad", 64'(m_axis_tdata[135:134]), 64'd0);
            if (surf_expected.size() == 0)
                report_mismatch("result transaction with nothing pending", 64'(got.top),
                                64'd0);
            else
                check_surface(got, surf_expected.pop_front());
        end
    end

    initial begin
        csag_pkg::cfg_t cfg;
        int n_items;
        error_count = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        set_idling(0);
        csr = csag_pkg::cfg_t'{32'd0, 14'd0, 14'd0, csag_pkg::FM_ANY, 2'd1};

        // directed rows: reset state, extremes and error codes typed in; the rest predicted
        add_row(1'b0, csr, 32'hFFFF_FFFF, 1'b1, format_error_result());
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_GREY, 14'd16383, 14'd16383,
                                       csag_pkg::FM_NONE, 2'd1},
                32'hFFFF_FFFF, 1'b1, single_plane(32'hFFFF_FFFF, 18'd16384, 30'd268419072));
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RGB4, 14'd16383, 14'd16383,
                                       csag_pkg::FM_ANY, 2'd1},
                32'h0, 1'b1, single_plane(32'h0, 18'd65536, 30'd1073676288));
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RGB4, 14'd0, 14'd0,
                                       csag_pkg::FM_NONE, 2'd1},
                32'h1234_5678, 1'b1, single_plane(32'h1234_5678, 18'd0, 30'd0));
        add_row(1'b1, csag_pkg::cfg_t'{32'hFFFF_FFFF, 14'd100, 14'd100,
                                       csag_pkg::FM_INTERLACED, 2'd2},
                32'hA5A5_A5A5, 1'b1, format_error_result());
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_YUYV, 14'd1, 14'd1,
                                       csag_pkg::FM_NONE, 2'd1},
                32'h40, 1'b1, single_plane(32'h40, 18'd64, 30'd64));
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_422P, 14'd1920, 14'd1080,
                                       csag_pkg::FM_INTERLACED, 2'd2},
                32'h8000_0000, 1'b0, '0);
        add_row(1'b0, csr, 32'h0, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_NV16, 14'd640, 14'd480,
                                       csag_pkg::FM_INTERLACED_TB, 2'd2},
                32'h1000_0000, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_NV61, 14'd641, 14'd481,
                                       csag_pkg::FM_INTERLACED_BT, 2'd3},
                32'hFFFF_F000, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_422P, 14'd16383, 14'd16383,
                                       csag_pkg::FM_SEQ_TB, 2'd2},
                32'hFFFF_FF00, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_422P, 14'd721, 14'd577,
                                       csag_pkg::FM_SEQ_BT, 2'd2},
                32'h1000, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_BA81, 14'd65, 14'd3, FM_SEVEN, 2'd2},
                32'h7FFF_FFFF, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RG12, 14'd100, 14'd7,
                                       csag_pkg::FM_ANY, 2'd0},
                32'h5555_5555, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RGB4, 14'd16383, 14'd16383,
                                       csag_pkg::FM_INTERLACED_BT, 2'd2},
                32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RGB4, 14'd16383, 14'd16383,
                                       csag_pkg::FM_SEQ_BT, 2'd2},
                32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_422P, 14'd0, 14'd16383,
                                       csag_pkg::FM_INTERLACED, 2'd2},
                32'h0, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_NV16, 14'd16383, 14'd0,
                                       csag_pkg::FM_SEQ_TB, 2'd1},
                32'hCAFE_0000, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_GBRG, 14'd3, 14'd5,
                                       csag_pkg::FM_NONE, 2'd1},
                32'h123, 1'b0, '0);
        add_row(1'b1, csag_pkg::cfg_t'{csag_pkg::FMT_RGBO, 14'd33, 14'd3,
                                       csag_pkg::FM_SEQ_TB, 2'd2},
                32'hDEAD_BEEF, 1'b0, '0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].set_cfg) begin
                wait_idle();
                program_config(stim_rows[i].cfg, 1'b0);
            end
            set_idling(i);
            send_buffer(stim_rows[i].base, stim_rows[i].typed, stim_rows[i].want);
        end

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            if ($urandom_range(99) < 85)
                cfg.pixel_format = KNOWN_FMTS[$urandom_range(0, NUM_KNOWN - 1)];
            else
                cfg.pixel_format = $urandom();
            cfg.frame_width = random_dimension();
            cfg.frame_height = random_dimension();
            cfg.field_mode = 3'($urandom_range(0, 7));
            cfg.parser_count = 2'($urandom_range(0, 3));
            program_config(cfg, 1'($urandom_range(1)));
            set_idling(ph);
            n_items = $urandom_range(16, 26);
            for (int k = 0; k < n_items; k++) begin
                if (ph == 6 && k == n_items / 2)
                    wait_idle();
                send_buffer(random_base(), 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (surf_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("** capture_surface_address_gen: PASSED **");
        else
            $display("** capture_surface_address_gen: FAILED **");
        $finish;
    end

endmodule
